>>> hdl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Operation codes, result kinds, parser phases and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam logic [7:0]  HEADER_FIRST  = 8'h55;
   localparam logic [7:0]  HEADER_SECOND = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET = 16'd300;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD_SUM = 2'd2,
      KIND_TIMEOUT = 2'd3
   } result_kind_type;

   typedef enum logic [7:0] {
      PH_HDR1    = 8'b0000_0001,
      PH_HDR2    = 8'b0000_0010,
      PH_VERSION = 8'b0000_0100,
      PH_COMMAND = 8'b0000_1000,
      PH_LEN_HI  = 8'b0001_0000,
      PH_LEN_LO  = 8'b0010_0000,
      PH_PAYLOAD = 8'b0100_0000,
      PH_CHECK   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data_byte;
      logic [7:0]      command_code;
      logic [7:0]      version_code;
      logic [15:0]     frame_length;
      logic [7:0]      computed_sum;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/sfr_parser.sv
// ---------------------------------------------------------------------------
// sfr_parser: frame state and per-item step logic
// Holds the frame phase, header fields, running sum, idle timer and timeout; forms at most
// one result for each accepted byte or tick.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_valid,
   input  wire sfr_pkg::op_type     step_op,
   input  wire logic [7:0]          step_byte,
   input  wire logic                csr_write,
   input  wire logic [15:0]         csr_value,
   output logic                     res_valid,
   output sfr_pkg::result_type      res
);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  sum_add;
   logic [15:0] idle_inc;
   logic [15:0] count_inc;
   logic [15:0] length_lo;

   assign sum_add   = sum_ff + step_byte;
   assign idle_inc  = (idle_ff == sfr_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign count_inc = count_ff + 16'd1;
   assign length_lo = {length_ff[15:8], step_byte};
   assign timeout_in = csr_write ? csr_value : timeout_ff;

   always_comb begin
      phase_in   = phase_ff;
      version_in = version_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      idle_in    = idle_ff;
      res_valid  = 1'b0;
      res.kind   = sfr_pkg::KIND_PAYLOAD;
      res.data_byte = step_byte;
      if (step_valid) begin
         if (step_op == sfr_pkg::OP_TICK) begin
            idle_in = idle_inc;
            if (phase_ff != sfr_pkg::PH_HDR1 && idle_inc > timeout_ff) begin
               res_valid     = 1'b1;
               res.kind      = sfr_pkg::KIND_TIMEOUT;
               res.data_byte = 8'd0;
               phase_in      = sfr_pkg::PH_HDR1;
            end
         end else begin
            unique case (phase_ff)
               sfr_pkg::PH_HDR1: begin
                  if (step_byte == sfr_pkg::HEADER_FIRST) begin
                     version_in = 8'd0;
                     command_in = 8'd0;
                     length_in  = 16'd0;
                     count_in   = 16'd0;
                     sum_in     = step_byte;
                     idle_in    = 16'd0;
                     phase_in   = sfr_pkg::PH_HDR2;
                  end
               end
               sfr_pkg::PH_HDR2: begin
                  if (step_byte == sfr_pkg::HEADER_SECOND) begin
                     sum_in   = sum_add;
                     idle_in  = 16'd0;
                     phase_in = sfr_pkg::PH_VERSION;
                  end else begin
                     phase_in = sfr_pkg::PH_HDR1;
                  end
               end
               sfr_pkg::PH_VERSION: begin
                  version_in = step_byte;
                  sum_in     = sum_add;
                  idle_in    = 16'd0;
                  phase_in   = sfr_pkg::PH_COMMAND;
               end
               sfr_pkg::PH_COMMAND: begin
                  command_in = step_byte;
                  sum_in     = sum_add;
                  idle_in    = 16'd0;
                  phase_in   = sfr_pkg::PH_LEN_HI;
               end
               sfr_pkg::PH_LEN_HI: begin
                  length_in = {step_byte, 8'd0};
                  sum_in    = sum_add;
                  idle_in   = 16'd0;
                  phase_in  = sfr_pkg::PH_LEN_LO;
               end
               sfr_pkg::PH_LEN_LO: begin
                  length_in = length_lo;
                  sum_in    = sum_add;
                  count_in  = 16'd0;
                  idle_in   = 16'd0;
                  phase_in  = (length_lo == 16'd0) ? sfr_pkg::PH_CHECK
                                                   : sfr_pkg::PH_PAYLOAD;
               end
               sfr_pkg::PH_PAYLOAD: begin
                  sum_in    = sum_add;
                  count_in  = count_inc;
                  idle_in   = 16'd0;
                  res_valid = 1'b1;
                  if (count_inc >= length_ff) begin
                     phase_in = sfr_pkg::PH_CHECK;
                  end
               end
               sfr_pkg::PH_CHECK: begin
                  res_valid = 1'b1;
                  res.kind  = (step_byte == sum_ff) ? sfr_pkg::KIND_GOOD
                                                    : sfr_pkg::KIND_BAD_SUM;
                  idle_in   = 16'd0;
                  phase_in  = sfr_pkg::PH_HDR1;
               end
               default: begin
                  phase_in = sfr_pkg::PH_HDR1;
               end
            endcase
         end
      end
      res.command_code = command_in;
      res.version_code = version_in;
      res.frame_length = length_in;
      res.computed_sum = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sfr_pkg::PH_HDR1;
         version_ff <= 8'd0;
         command_ff <= 8'd0;
         length_ff  <= 16'd0;
         count_ff   <= 16'd0;
         sum_ff     <= 8'd0;
         idle_ff    <= 16'd0;
         timeout_ff <= sfr_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff   <= phase_in;
         version_ff <= version_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         idle_ff    <= idle_in;
         timeout_ff <= timeout_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sfr_out_queue.sv
// ---------------------------------------------------------------------------
// sfr_out_queue: two-entry result register with skid slot
// Registers each result and keeps one more while the head waits.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_out_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire sfr_pkg::result_type push_data,
   output logic                     push_ready,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output sfr_pkg::result_type      pop_data
);

   logic [1:0]          fill_ff, fill_in;
   sfr_pkg::result_type head_ff, head_in;
   sfr_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop        = pop_valid && pop_ready;
   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = head_ff;

   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      case (fill_ff)
         2'd0: begin
            if (push_valid) begin
               head_in = push_data;
               fill_in = 2'd1;
            end
         end
         2'd1: begin
            if (push_valid && pop) begin
               head_in = push_data;
            end else if (push_valid) begin
               skid_in = push_data;
               fill_in = 2'd2;
            end else if (pop) begin
               fill_in = 2'd0;
            end
         end
         default: begin
            if (pop) begin
               head_in = skid_ff;
               fill_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

>>> hdl/serial_frame_receiver.sv
// Each result is registered in the head slot, or the skid slot if the head waits.
// Throughput: one byte or tick per cycle; a two-entry result register lets
// items keep flowing while one result waits, and stalls input once both fill.
// Reset (synchronous): phase back to header search, fields and idle timer
// cleared, timeout register to 300 ticks, result register emptied.
// ---------------------------------------------------------------------------
// serial_frame_receiver: UART frame parser with length and additive checksum
// Streams payload bytes and reports frame good, bad checksum or timeout.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // [7:0] data_byte, [15:8] command_code,
                                        // [23:16] version_code,
                                        // [39:24] frame_length, [47:40] computed_sum
   output logic [1:0]       rsp_tuser,  // [1:0] result_kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data    // timeout_ticks
);

   logic                step_valid;
   logic                res_valid;
   sfr_pkg::result_type res;
   sfr_pkg::result_type head;
   sfr_pkg::op_type     step_op;

   assign step_valid = req_tvalid && req_tready;
   assign step_op    = sfr_pkg::op_type'(req_tuser);
   assign csr_ready  = 1'b1;

   sfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_op    (step_op),
      .step_byte  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .res_valid  (res_valid),
      .res        (res)
   );

   sfr_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .push_ready (req_tready),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (head)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tdata = {head.computed_sum, head.frame_length, head.version_code,
                       head.command_code, head.data_byte};

endmodule

`default_nettype wire

>>> tb/sv/serial_frame_receiver_checker.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_checker: scoreboard for the serial frame receiver
// Watches the request, response and register channels, tracks the parser
// state on every request transfer and compares each response transfer,
// field by field, with the oldest result still awaited.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] operation
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,  // [7:0] data_byte, [15:8] command_code,
                                        // [23:16] version_code,
                                        // [39:24] frame_length, [47:40] computed_sum
   input  wire logic [1:0]  rsp_tuser,  // [1:0] result_kind
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_data,   // timeout_ticks
   output int               error_count,
   output int               awaited_count
);

   logic [15:0]         timeout_ticks;
   sfr_pkg::phase_type  phase;
   logic [7:0]          version_held;
   logic [7:0]          command_held;
   logic [15:0]         length_held;
   logic [15:0]         payload_seen;
   logic [7:0]          sum_acc;
   logic [15:0]         idle_count;
   sfr_pkg::result_type awaited_results[$];
   sfr_pkg::result_type oldest;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   function automatic sfr_pkg::result_type frame_result(
      input sfr_pkg::result_kind_type kind, input logic [7:0] data_byte);
      sfr_pkg::result_type outcome;
      outcome.kind         = kind;
      outcome.data_byte    = data_byte;
      outcome.command_code = command_held;
      outcome.version_code = version_held;
      outcome.frame_length = length_held;
      outcome.computed_sum = sum_acc;
      return outcome;
   endfunction

   task automatic queue_result(input sfr_pkg::result_type outcome);
      awaited_results = {awaited_results, outcome};
   endtask

   task automatic advance_parser(input sfr_pkg::op_type op, input logic [7:0] value);
      if (op == sfr_pkg::OP_TICK) begin
         if (idle_count != sfr_pkg::IDLE_MAX) idle_count++;
         if (phase != sfr_pkg::PH_HDR1 && idle_count > timeout_ticks) begin
            queue_result(frame_result(sfr_pkg::KIND_TIMEOUT, 8'h00));
            phase = sfr_pkg::PH_HDR1;
         end
      end else begin
         case (phase)
            sfr_pkg::PH_HDR1: begin
               if (value == sfr_pkg::HEADER_FIRST) begin
                  version_held = 8'h00;
                  command_held = 8'h00;
                  length_held  = 16'h0000;
                  payload_seen = 16'h0000;
                  sum_acc      = value;
                  phase        = sfr_pkg::PH_HDR2;
                  idle_count   = 16'h0000;
               end
            end
            sfr_pkg::PH_HDR2: begin
               if (value == sfr_pkg::HEADER_SECOND) begin
                  sum_acc    = sum_acc + value;
                  phase      = sfr_pkg::PH_VERSION;
                  idle_count = 16'h0000;
               end else begin
                  phase = sfr_pkg::PH_HDR1;
               end
            end
            sfr_pkg::PH_VERSION: begin
               version_held = value;
               sum_acc      = sum_acc + value;
               phase        = sfr_pkg::PH_COMMAND;
               idle_count   = 16'h0000;
            end
            sfr_pkg::PH_COMMAND: begin
               command_held = value;
               sum_acc      = sum_acc + value;
               phase        = sfr_pkg::PH_LEN_HI;
               idle_count   = 16'h0000;
            end
            sfr_pkg::PH_LEN_HI: begin
               length_held = {value, 8'h00};
               sum_acc     = sum_acc + value;
               phase       = sfr_pkg::PH_LEN_LO;
               idle_count  = 16'h0000;
            end
            sfr_pkg::PH_LEN_LO: begin
               length_held  = {length_held[15:8], value};
               sum_acc      = sum_acc + value;
               payload_seen = 16'h0000;
               phase        = (length_held == 16'h0000) ? sfr_pkg::PH_CHECK
                                                        : sfr_pkg::PH_PAYLOAD;
               idle_count   = 16'h0000;
            end
            sfr_pkg::PH_PAYLOAD: begin
               sum_acc      = sum_acc + value;
               payload_seen = payload_seen + 16'd1;
               if (payload_seen >= length_held) phase = sfr_pkg::PH_CHECK;
               idle_count   = 16'h0000;
               queue_result(frame_result(sfr_pkg::KIND_PAYLOAD, value));
            end
            default: begin
               queue_result(frame_result(
                  (value == sum_acc) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD_SUM, value));
               phase      = sfr_pkg::PH_HDR1;
               idle_count = 16'h0000;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = sfr_pkg::TIMEOUT_RESET;
         phase         = sfr_pkg::PH_HDR1;
         version_held  = 8'h00;
         command_held  = 8'h00;
         length_held   = 16'h0000;
         payload_seen  = 16'h0000;
         sum_acc       = 8'h00;
         idle_count    = 16'h0000;
         awaited_results.delete();
         error_count   = 0;
         awaited_count = 0;
      end else begin
         if (csr_valid && csr_ready) timeout_ticks = csr_data;
         if (req_tvalid && req_tready)
            advance_parser(sfr_pkg::op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with none awaited", {14'd0, rsp_tuser},
                               16'h0000);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_tuser != oldest.kind)
                  report_mismatch("result_kind", {14'd0, rsp_tuser}, {14'd0, oldest.kind});
               if (rsp_tdata[7:0] != oldest.data_byte)
                  report_mismatch("data_byte", {8'h00, rsp_tdata[7:0]},
                                  {8'h00, oldest.data_byte});
               if (rsp_tdata[15:8] != oldest.command_code)
                  report_mismatch("command_code", {8'h00, rsp_tdata[15:8]},
                                  {8'h00, oldest.command_code});
               if (rsp_tdata[23:16] != oldest.version_code)
                  report_mismatch("version_code", {8'h00, rsp_tdata[23:16]},
                                  {8'h00, oldest.version_code});
               if (rsp_tdata[39:24] != oldest.frame_length)
                  report_mismatch("frame_length", rsp_tdata[39:24], oldest.frame_length);
               if (rsp_tdata[47:40] != oldest.computed_sum)
                  report_mismatch("computed_sum", {8'h00, rsp_tdata[47:40]},
                                  {8'h00, oldest.computed_sum});
            end
         end
         awaited_count = awaited_results.size();
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/serial_frame_receiver_test.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_test: stimulus and verdict for the frame receiver
// Sends directed frames and timeouts, then random frames, broken frames,
// noise and tick bursts under several timeout settings, with random gaps on
// the request side and stalls on the response side. The checker beside the
// block predicts and compares every transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_test;

   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 105;
   localparam int WHOLE_FRAME   = 1 << 30;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = 16'h0000;

   int          error_count;
   int          awaited_count;
   bit          steady = 1'b0;
   logic [15:0] timeout_now = sfr_pkg::TIMEOUT_RESET;
   int          items_sent = 0;
   logic [15:0] timeout_plan [7];
   int          round_goal;

   always #2 clock = ~clock;

   serial_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   serial_frame_receiver_checker monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic int tick_burst();
      if (timeout_now <= 16'd40) return $urandom_range(1, int'(timeout_now) + 1);
      return $urandom_range(1, 3);
   endfunction

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input sfr_pkg::op_type op, input logic [7:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++)
         send_item(sfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // send the first keep bytes of a frame; loose sprinkles tick bursts in between
   task automatic send_frame(input logic [7:0] version, input logic [7:0] command,
                             input logic [15:0] length, input bit good_sum,
                             input int keep, input bit loose);
      logic [7:0] frame_bytes[$];
      logic [7:0] sum;
      int         last;
      frame_bytes = {sfr_pkg::HEADER_FIRST, sfr_pkg::HEADER_SECOND, version, command,
                     length[15:8], length[7:0]};
      for (int i = 0; i < int'(length) && frame_bytes.size() < keep; i++)
         frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
      sum = 8'h00;
      foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
      frame_bytes = {frame_bytes,
                     good_sum ? sum : (sum ^ 8'($urandom_range(1, 255)))};
      last = (keep < frame_bytes.size()) ? keep : frame_bytes.size();
      for (int i = 0; i < last; i++) begin
         if (loose && $urandom_range(0, 9) == 0) send_ticks(tick_burst());
         send_item(sfr_pkg::OP_BYTE, frame_bytes[i]);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid   <= 1'b0;
      timeout_now = value;
   endtask

   task automatic random_traffic();
      int         roll;
      int         count;
      logic [15:0] length;
      roll = $urandom_range(0, 99);
      length = 16'($urandom_range(0, 6));
      if (roll < 65) begin
         send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), length,
                    $urandom_range(0, 4) != 0, WHOLE_FRAME, 1'b1);
      end else if (roll < 77 && timeout_now <= 16'd40) begin
         if ($urandom_range(0, 3) == 0) length = 16'($urandom_range(256, 260));
         send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), length,
                    1'b1, $urandom_range(1, 12), 1'b0);
         send_ticks(int'(timeout_now) + 1);
      end else if (roll < 90) begin
         count = $urandom_range(1, 4);
         for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
               0:       send_item(sfr_pkg::OP_BYTE, sfr_pkg::HEADER_FIRST);
               1:       send_item(sfr_pkg::OP_BYTE, sfr_pkg::HEADER_SECOND);
               default: send_item(sfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         send_ticks($urandom_range(1, 4));
      end
   endtask

   initial begin : sink_pacing
      int span;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (steady || $urandom_range(0, 99) < 60) begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 16);
         end else begin
            rsp_tready <= 1'b0;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                               : $urandom_range(1, 3);
         end
         repeat (span) @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: tick while searching, extreme header bytes, zero length,
      // bad checksum, wrong second header byte not retried as a first one
      send_ticks(1);
      send_frame(8'h00, 8'hFF, 16'h0000, 1'b1, WHOLE_FRAME, 1'b0);
      send_frame(8'hFF, 8'h00, 16'h0001, 1'b0, WHOLE_FRAME, 1'b0);
      send_item(sfr_pkg::OP_BYTE, sfr_pkg::HEADER_FIRST);
      send_item(sfr_pkg::OP_BYTE, sfr_pkg::HEADER_FIRST);
      send_item(sfr_pkg::OP_BYTE, sfr_pkg::HEADER_SECOND);
      send_item(sfr_pkg::OP_BYTE, 8'h00);

      // reset timeout: abandon a maximum length frame on the tick after 300
      send_frame(8'h12, 8'h34, 16'hFFFF, 1'b1, 7, 1'b0);
      send_ticks(int'(sfr_pkg::TIMEOUT_RESET) + 1);

      // timeout at zero abandons on the first tick
      write_timeout(16'h0000);
      send_frame(8'hA5, 8'h5A, 16'h0003, 1'b1, 2, 1'b0);
      send_ticks(3);
      write_timeout(16'h0001);
      send_frame(8'h3C, 8'hC3, 16'h0004, 1'b1, 8, 1'b0);
      send_ticks(2);

      timeout_plan = '{16'd2, 16'd5, 16'd20, 16'd0, 16'd1, 16'hFFFF, 16'd12};
      timeout_plan[3] = 16'($urandom_range(1, 65535));
      for (int round = 0; round < 7; round++) begin
         write_timeout(timeout_plan[round]);
         steady = (round == 4);
         round_goal = items_sent + RANDOM_ITEMS / 7;
         while (items_sent < round_goal) random_traffic();
         steady = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && awaited_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
